>>> rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Condition that must always hold outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

>>> rtl/core/skt_pkg.sv
package skt_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned PayW    = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_REM_RANGE = 3'd2,
    CMD_NEAR      = 3'd3,
    CMD_RANGE     = 3'd4,
    CMD_READ_IDX  = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_FND  = 2'd2,
    ST_BAD_IDX  = 2'd3
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic signed [KeyW-1:0] key_a;
    logic signed [KeyW-1:0] key_b;
    logic [PayW-1:0]   payload;
    logic [IndexW-1:0] index;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic signed [KeyW-1:0] total_key;
    logic               entry_valid;
    logic signed [KeyW-1:0] entry_key;
    logic [PayW-1:0]    entry_payload;
    logic               next_valid;
    logic signed [KeyW-1:0] next_key;
    logic [PayW-1:0]    next_payload;
    logic               last;
  } rsp_t;

endpackage

>>> rtl/core/sorted_key_table_core.sv
// Sorted key table: up to DEPTH (key, payload) entries kept in ascending signed
// key order in one synchronous memory (one read and one write port, registered
// read data). Insert, remove, range removal, near and range queries first scan
// the table from position 0, one entry per cycle, to find their ranks; insert
// and removal then move the tail one entry at a time (read, then write back).
// A range query then reads and emits each matching entry in turn. Read index,
// clear and nop need no scan. A result waiting for the consumer holds the
// block in its output states.
// No clearing pass is needed after reset.
`include "assert_macros.svh"

module sorted_key_table_core import skt_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CountW-1:0] DepthC = CountW'(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // issue reads 0..count-1
  localparam logic [3:0] S_DEC   = 4'd2;  // decide after scan
  localparam logic [3:0] S_MOVE  = 4'd3;  // tail move, read phase
  localparam logic [3:0] S_MOVEW = 4'd4;  // tail move, write phase
  localparam logic [3:0] S_LAST  = 4'd5;  // read last key for total
  localparam logic [3:0] S_LASTW = 4'd6;
  localparam logic [3:0] S_RNG   = 4'd7;  // range query emission read
  localparam logic [3:0] S_RNGW  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_IDX   = 4'd10;
  localparam logic [3:0] S_IDXW  = 4'd11;

  logic [KeyW+PayW-1:0] mem_q [DEPTH];
  logic [KeyW+PayW-1:0] rdata_q;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [KeyW+PayW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  logic [3:0]        state_q, state_d;
  req_t              req_q, req_d;
  logic [CountW-1:0] count_q, count_d;
  logic signed [KeyW-1:0] total_q, total_d;
  // scan: issue pointer and response pointer
  logic [CountW-1:0] ptr_q, ptr_d;
  logic              rv_q, rv_d;       // read response valid this cycle
  logic [CountW-1:0] rptr_q, rptr_d;   // position of the response
  logic [CountW-1:0] lo_q, lo_d;       // rank_lt(key_a)
  logic [CountW-1:0] hi_q, hi_d;       // rank_le(key_a or key_b)
  logic [CountW-1:0] pa_q, pa_d;       // rank_le(key_a)
  logic              eq_q, eq_d;       // key_a present
  logic [KeyW+PayW-1:0] pent_q, pent_d; // predecessor entry
  logic [KeyW+PayW-1:0] nent_q, nent_d; // successor entry
  logic              nfound_q, nfound_d;
  logic [CountW-1:0] mv_q, mv_d;       // move pointer
  rsp_t              res_q, res_d;     // result waiting for S_OUT
  rsp_t              out_q, out_d;
  logic              ov_q, ov_d;

  logic signed [KeyW-1:0] rkey;
  logic [PayW-1:0]        rpay;
  assign rkey = rdata_q[KeyW+PayW-1:PayW];
  assign rpay = rdata_q[PayW-1:0];

  logic out_free;
  assign out_free = !ov_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  function automatic rsp_t base_rsp(input logic [StatusW-1:0] st,
                                    input logic [CountW-1:0] c,
                                    input logic signed [KeyW-1:0] t);
    rsp_t r;
    r = '0;
    r.status    = st;
    r.count     = c;
    r.total_key = t;
    r.last      = 1'b1;
    return r;
  endfunction

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    count_d  = count_q;
    total_d  = total_q;
    ptr_d    = ptr_q;
    rv_d     = 1'b0;
    rptr_d   = ptr_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    pa_d     = pa_q;
    eq_d     = eq_q;
    pent_d   = pent_q;
    nent_d   = nent_q;
    nfound_d = nfound_q;
    mv_d     = mv_q;
    res_d    = res_q;
    out_d    = out_q;
    ov_d     = ov_q && !out_ready_i;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = ptr_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          ptr_d    = '0;
          lo_d     = '0;
          hi_d     = '0;
          pa_d     = '0;
          eq_d     = 1'b0;
          nfound_d = 1'b0;
          case (cmd_e'(in_data_i.command))
            CMD_CLEAR: begin
              count_d = '0;
              total_d = '0;
              state_d = S_OUT;
              res_d   = base_rsp(ST_OK, '0, '0);
            end
            CMD_NOP: begin
              state_d = S_OUT;
              res_d   = base_rsp(ST_OK, count_q, total_q);
            end
            CMD_READ_IDX: begin
              state_d = S_IDX;
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end

      S_IDX: begin
        raddr   = req_q.index[AW-1:0];
        state_d = S_IDXW;
      end

      S_IDXW: begin
        raddr = req_q.index[AW-1:0];
        if (out_free) begin
          out_d = base_rsp(ST_OK, count_q, total_q);
          if ({1'b0, req_q.index} < count_q) begin
            out_d.entry_valid   = 1'b1;
            out_d.entry_key     = rkey;
            out_d.entry_payload = rpay;
          end else begin
            out_d.status = ST_BAD_IDX;
          end
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        if (rv_q) begin
          if (rkey < req_q.key_a) begin
            lo_d = rptr_q + 1'b1;
          end
          if (rkey <= req_q.key_a) begin
            pa_d   = rptr_q + 1'b1;
            pent_d = rdata_q;
            eq_d   = (rkey == req_q.key_a);
          end
          if (rkey >= req_q.key_a && !nfound_q) begin
            nent_d   = rdata_q;
            nfound_d = 1'b1;
          end
          if (rkey <= req_q.key_b) begin
            hi_d = rptr_q + 1'b1;
          end
        end
        if (ptr_q < count_q) begin
          rv_d   = 1'b1;
          rptr_d = ptr_q;
          ptr_d  = ptr_q + 1'b1;
        end else if (!rv_q) begin
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        case (cmd_e'(req_q.command))
          CMD_INSERT: begin
            if (eq_q) begin
              we      = 1'b1;
              waddr   = AW'(pa_q - 1'b1);
              wdata   = {req_q.key_a, req_q.payload};
              res_d   = base_rsp(ST_OK, count_q, total_q);
              state_d = S_OUT;
            end else if (count_q >= DepthC) begin
              res_d   = base_rsp(ST_FULL, count_q, total_q);
              state_d = S_OUT;
            end else begin
              mv_d    = count_q;
              state_d = S_MOVE;
            end
          end
          CMD_REMOVE: begin
            if (eq_q) begin
              lo_d    = pa_q - 1'b1;
              hi_d    = pa_q;
              mv_d    = pa_q - 1'b1;
              state_d = S_MOVE;
            end else begin
              res_d   = base_rsp(ST_NOT_FND, count_q, total_q);
              state_d = S_OUT;
            end
          end
          CMD_REM_RANGE: begin
            if (hi_q > lo_q) begin
              mv_d    = lo_q;
              state_d = S_MOVE;
            end else begin
              res_d   = base_rsp(ST_NOT_FND, count_q, total_q);
              state_d = S_OUT;
            end
          end
          CMD_NEAR: begin
            res_d = base_rsp((pa_q != '0 || nfound_q) ? ST_OK : ST_NOT_FND,
                             count_q, total_q);
            if (pa_q != '0) begin
              res_d.entry_valid   = 1'b1;
              res_d.entry_key     = pent_q[KeyW+PayW-1:PayW];
              res_d.entry_payload = pent_q[PayW-1:0];
            end
            if (nfound_q) begin
              res_d.next_valid   = 1'b1;
              res_d.next_key     = nent_q[KeyW+PayW-1:PayW];
              res_d.next_payload = nent_q[PayW-1:0];
            end
            state_d = S_OUT;
          end
          CMD_RANGE: begin
            if (hi_q > lo_q) begin
              mv_d    = lo_q;
              state_d = S_RNG;
            end else begin
              res_d   = base_rsp(ST_NOT_FND, count_q, total_q);
              state_d = S_OUT;
            end
          end
          default: begin
            res_d   = base_rsp(ST_OK, count_q, total_q);
            state_d = S_OUT;
          end
        endcase
      end

      // Insert moves entries up from the top; removal moves them down from lo.
      S_MOVE: begin
        if (cmd_e'(req_q.command) == CMD_INSERT) begin
          if (mv_q > pa_q) begin
            raddr   = AW'(mv_q - 1'b1);
            state_d = S_MOVEW;
          end else begin
            we      = 1'b1;
            waddr   = AW'(pa_q);
            wdata   = {req_q.key_a, req_q.payload};
            count_d = count_q + 1'b1;
            state_d = S_LAST;
          end
        end else begin
          if (mv_q + (hi_q - lo_q) < count_q) begin
            raddr   = AW'(mv_q + (hi_q - lo_q));
            state_d = S_MOVEW;
          end else begin
            count_d = count_q - (hi_q - lo_q);
            state_d = S_LAST;
          end
        end
      end

      S_MOVEW: begin
        we    = 1'b1;
        wdata = rdata_q;
        if (cmd_e'(req_q.command) == CMD_INSERT) begin
          waddr = AW'(mv_q);
          mv_d  = mv_q - 1'b1;
        end else begin
          waddr = AW'(mv_q);
          mv_d  = mv_q + 1'b1;
        end
        state_d = S_MOVE;
      end

      S_LAST: begin
        raddr   = AW'(count_q - 1'b1);
        state_d = S_LASTW;
      end

      S_LASTW: begin
        total_d = (count_q != '0) ? rkey : '0;
        res_d   = base_rsp(ST_OK, count_q, total_d);
        state_d = S_OUT;
      end

      S_RNG: begin
        raddr   = AW'(mv_q);
        state_d = S_RNGW;
      end

      S_RNGW: begin
        raddr = AW'(mv_q);
        if (out_free) begin
          out_d               = base_rsp(ST_OK, count_q, total_q);
          out_d.entry_valid   = 1'b1;
          out_d.entry_key     = rkey;
          out_d.entry_payload = rpay;
          out_d.last          = (mv_q + 1'b1 == hi_q);
          ov_d                = 1'b1;
          mv_d                = mv_q + 1'b1;
          state_d             = (mv_q + 1'b1 == hi_q) ? S_IDLE : S_RNG;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      ov_q     <= 1'b0;
      rv_q     <= 1'b0;
      ptr_q    <= '0;
      rptr_q   <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      pa_q     <= '0;
      eq_q     <= 1'b0;
      nfound_q <= 1'b0;
      mv_q     <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      ov_q     <= ov_d;
      rv_q     <= rv_d;
      ptr_q    <= ptr_d;
      rptr_q   <= rptr_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      pa_q     <= pa_d;
      eq_q     <= eq_d;
      nfound_q <= nfound_d;
      mv_q     <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pent_q <= pent_d;
    nent_q <= nent_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  `ASSERT_ALWAYS(a_count_range, clk_i, rst_ni, count_q <= DepthC,
                 "entry count exceeds depth")
  `ASSERT_IMPL(a_empty_total, clk_i, rst_ni, ov_q && out_q.count == '0,
               out_q.total_key == '0, "empty table with nonzero total")
  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE,
               !in_ready_o, "input ready while busy")

endmodule
